### rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared constants, types and helper functions of the Bayer demosaic block.
// ----------------------------------------------------------------------------
package bbd_pkg;

   // Frame geometry limits.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   // Counter and size widths that follow from the limits.
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

   // Pixel and line memory entry widths.
   localparam int PIX_W  = 8;
   localparam int LINE_W = 2 * PIX_W;

   // Register file port widths.
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // Request operations.
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_DRAIN  = 1'b1
   } op_type;

   // Position information of the pixel that a request emits.
   typedef struct packed {
      logic emit;
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
      logic even_row;
      logic even_col;
      logic frame_end;
   } pix_type;

   // One request on its way into the line memory.
   typedef struct packed {
      logic             is_sample;
      logic [COL_W-1:0] column;
      pix_type          pix;
   } item_type;

   // 3x3 neighborhood, indexed [row][column], row 0 on top, column 0 on the left.
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   // Clamp the programmed width into the supported range.
   function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] value);
      if (int'(value) < 2) begin
         return WID_W'(2);
      end else if (int'(value) > MAX_WIDTH) begin
         return WID_W'(MAX_WIDTH);
      end else begin
         return WID_W'(value);
      end
   endfunction

   // Clamp the programmed height into the supported range.
   function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_HEIGHT_W-1:0] value);
      if (int'(value) < 2) begin
         return HGT_W'(2);
      end else if (int'(value) > MAX_HEIGHT) begin
         return HGT_W'(MAX_HEIGHT);
      end else begin
         return HGT_W'(value);
      end
   endfunction

endpackage

### rtl/bbd_ram.sv
// ----------------------------------------------------------------------------
// bbd_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bbd_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array, written one entry per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data is held until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bbd_ctrl.sv
// ----------------------------------------------------------------------------
// bbd_ctrl
// Frame registers and position counters. Classifies each request and tags it
// with the line memory column and the position of the pixel it emits.
// ----------------------------------------------------------------------------
module bbd_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [bbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               accept,
   input  logic                               req_operation,
   output logic                               kept,
   output bbd_pkg::item_type                  item
);

   logic [bbd_pkg::WID_W-1:0] width_ff, width_in;
   logic [bbd_pkg::HGT_W-1:0] height_ff, height_in;
   logic [bbd_pkg::COL_W-1:0] icol_ff, icol_in;
   logic [bbd_pkg::ROW_W-1:0] irow_ff, irow_in;
   logic [bbd_pkg::COL_W-1:0] ocol_ff, ocol_in;
   logic [bbd_pkg::ROW_W-1:0] orow_ff, orow_in;
   logic                      draining_ff, draining_in;

   logic                      is_drain;
   logic                      emit;
   logic                      lin_ok;
   logic [bbd_pkg::WID_W-1:0] width_m1;
   logic [bbd_pkg::HGT_W-1:0] height_m1;
   logic                      out_last_col, out_last_row;
   logic                      in_last_col, in_last_row;

   // Request classification and pixel position flags.
   always_comb begin
      is_drain     = (req_operation == bbd_pkg::OP_DRAIN);
      width_m1     = width_ff - 1'b1;
      height_m1    = height_ff - 1'b1;
      out_last_col = (bbd_pkg::WID_W'(ocol_ff) == width_m1);
      out_last_row = (bbd_pkg::HGT_W'(orow_ff) == height_m1);
      in_last_col  = (bbd_pkg::WID_W'(icol_ff) == width_m1);
      in_last_row  = (bbd_pkg::HGT_W'(irow_ff) == height_m1);
      // The first pixel appears once one row and one sample have gone by.
      lin_ok       = (irow_ff > bbd_pkg::ROW_W'(1)) ||
                     ((irow_ff == bbd_pkg::ROW_W'(1)) && (icol_ff != '0));

      kept = is_drain ? draining_ff : !draining_ff;
      emit = is_drain ? draining_ff : (!draining_ff && lin_ok);

      item.is_sample = !is_drain;
      // A drain step still reads the column right of the emitted pixel.
      if (is_drain) begin
         item.column = out_last_col ? '0 : ocol_ff + 1'b1;
      end else begin
         item.column = icol_ff;
      end
      item.pix.emit      = emit;
      item.pix.has_up    = (orow_ff != '0);
      item.pix.has_down  = !out_last_row;
      item.pix.has_left  = (ocol_ff != '0);
      item.pix.has_right = !out_last_col;
      item.pix.even_row  = !orow_ff[0];
      item.pix.even_col  = !ocol_ff[0];
      item.pix.frame_end = out_last_col && out_last_row;
   end

   // Next state of registers and counters.
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      icol_in     = icol_ff;
      irow_in     = irow_ff;
      ocol_in     = ocol_ff;
      orow_in     = orow_ff;
      draining_in = draining_ff;

      if (csr_write) begin
         case (csr_index)
            bbd_pkg::CSR_FRAME_WIDTH: begin
               width_in    = bbd_pkg::clamp_width(csr_wdata[bbd_pkg::CFG_WIDTH_W-1:0]);
               icol_in     = '0;
               irow_in     = '0;
               ocol_in     = '0;
               orow_in     = '0;
               draining_in = 1'b0;
            end
            bbd_pkg::CSR_FRAME_HEIGHT: begin
               height_in   = bbd_pkg::clamp_height(csr_wdata[bbd_pkg::CFG_HEIGHT_W-1:0]);
               icol_in     = '0;
               irow_in     = '0;
               ocol_in     = '0;
               orow_in     = '0;
               draining_in = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         // Output position advances with every emitted pixel.
         if (emit) begin
            if (out_last_col) begin
               ocol_in = '0;
               if (out_last_row) begin
                  orow_in     = '0;
                  draining_in = 1'b0;
               end else begin
                  orow_in = orow_ff + 1'b1;
               end
            end else begin
               ocol_in = ocol_ff + 1'b1;
            end
         end
         // Input position advances with every sample of the frame.
         if (!is_drain && !draining_ff) begin
            if (in_last_col) begin
               icol_in = '0;
               if (in_last_row) begin
                  irow_in     = '0;
                  draining_in = 1'b1;
               end else begin
                  irow_in = irow_ff + 1'b1;
               end
            end else begin
               icol_in = icol_ff + 1'b1;
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= bbd_pkg::clamp_width(bbd_pkg::CFG_WIDTH_W'(1024));
         height_ff   <= bbd_pkg::clamp_height(bbd_pkg::CFG_HEIGHT_W'(1024));
         icol_ff     <= '0;
         irow_ff     <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         draining_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         icol_ff     <= icol_in;
         irow_ff     <= irow_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         draining_ff <= draining_in;
      end
   end

endmodule

### rtl/bbd_window.sv
// ----------------------------------------------------------------------------
// bbd_window
// Two-row line memory and the 3x3 neighborhood window. Each column entry
// holds the two older rows; a sample reads its column, shifts the new
// three-high column into the window and writes the entry back one row down.
// ----------------------------------------------------------------------------
module bbd_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  bbd_pkg::item_type             item,
   input  logic [bbd_pkg::PIX_W-1:0]     sample,
   input  logic                          p3_free,
   output logic                          p1_free,
   output logic                          p2_load,
   output bbd_pkg::pix_type              p2_pix,
   output bbd_pkg::win_type              win
);

   logic                          p1_valid_ff, p1_valid_in;
   bbd_pkg::item_type             p1_item_ff;
   logic [bbd_pkg::PIX_W-1:0]     p1_sample_ff;
   logic                          p2_valid_ff, p2_valid_in;
   bbd_pkg::pix_type              p2_pix_ff;
   bbd_pkg::win_type              win_ff, win_in;

   logic                          p1_go, p2_go, p2_free;
   logic                          ram_wr_en;
   logic [bbd_pkg::LINE_W-1:0]    ram_wr_data;
   logic [bbd_pkg::LINE_W-1:0]    ram_rd_data;

   // Stage handshakes: a stage moves when the one after it is free.
   always_comb begin
      p2_go       = p2_valid_ff && (!p2_pix_ff.emit || p3_free);
      p2_free     = !p2_valid_ff || p2_go;
      p1_go       = p1_valid_ff && p2_free;
      p1_free     = !p1_valid_ff || p1_go;
      p1_valid_in = take || (p1_valid_ff && !p1_go);
      p2_valid_in = p1_go || (p2_valid_ff && !p2_go);
      p2_load     = p2_go && p2_pix_ff.emit;
   end

   // Write back: newest sample moves to the upper half, the old upper half down.
   always_comb begin
      ram_wr_en   = p1_go && p1_item_ff.is_sample;
      ram_wr_data = {p1_sample_ff, ram_rd_data[bbd_pkg::LINE_W-1:bbd_pkg::PIX_W]};
   end

   bbd_ram #(
      .WIDTH (bbd_pkg::LINE_W),
      .DEPTH (bbd_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (p1_item_ff.column),
      .wr_data (ram_wr_data),
      .rd_en   (take),
      .rd_addr (item.column),
      .rd_data (ram_rd_data)
   );

   // Window shift: columns move left, the fetched column enters on the right.
   always_comb begin
      win_in = win_ff;
      if (p1_go) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = ram_rd_data[bbd_pkg::PIX_W-1:0];
         win_in[1][2] = ram_rd_data[bbd_pkg::LINE_W-1:bbd_pkg::PIX_W];
         win_in[2][2] = p1_sample_ff;
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
      end
   end

   // Stage payloads and the window.
   always_ff @(posedge clock) begin
      if (take) begin
         p1_item_ff   <= item;
         p1_sample_ff <= sample;
      end
      if (p1_go) begin
         p2_pix_ff <= p1_item_ff.pix;
      end
      win_ff <= win_in;
   end

   assign p2_pix = p2_pix_ff;
   assign win    = win_ff;

endmodule

### rtl/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear interpolation: masks out-of-frame neighbors, sums the rest per
// color, then divides by the neighbor count into the output register.
// ----------------------------------------------------------------------------
module bbd_interp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          p2_load,
   input  bbd_pkg::pix_type              p2_pix,
   input  bbd_pkg::win_type              win,
   input  logic                          rsp_stall,
   output logic                          p3_free,
   output logic                          rsp_valid,
   output logic [bbd_pkg::PIX_W-1:0]     rsp_blue,
   output logic [bbd_pkg::PIX_W-1:0]     rsp_green,
   output logic [bbd_pkg::PIX_W-1:0]     rsp_red,
   output logic                          rsp_frame_end
);

   localparam int SUM_W = bbd_pkg::PIX_W + 2;
   localparam int CNT_W = 3;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
   } chan_type;

   logic                      p3_valid_ff, p3_valid_in;
   chan_type                  p3_blue_ff, p3_green_ff, p3_red_ff;
   logic                      p3_fe_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bbd_pkg::PIX_W-1:0] rsp_blue_ff, rsp_green_ff, rsp_red_ff;
   logic                      rsp_fe_ff;

   logic                      out_free;
   logic [SUM_W-1:0]          up, dn, lf, rt, ul, ur, dl, dr;
   chan_type                  own, ortho, diag, horiz, vert;
   chan_type                  blue, green, red;

   // Truncated mean of up to four 8-bit values; a third is taken by reciprocal.
   function automatic logic [bbd_pkg::PIX_W-1:0] mean(input chan_type ch);
      logic [SUM_W+10:0] prod;
      prod = ch.sum * 11'd683;
      case (ch.cnt)
         3'd1:    return ch.sum[bbd_pkg::PIX_W-1:0];
         3'd2:    return ch.sum[bbd_pkg::PIX_W:1];
         3'd3:    return prod[bbd_pkg::PIX_W+10:11];
         3'd4:    return ch.sum[bbd_pkg::PIX_W+1:2];
         default: return '0;
      endcase
   endfunction

   // Neighbors that lie outside the frame count as zero and are not counted.
   always_comb begin
      up = p2_pix.has_up    ? SUM_W'(win[0][1]) : '0;
      dn = p2_pix.has_down  ? SUM_W'(win[2][1]) : '0;
      lf = p2_pix.has_left  ? SUM_W'(win[1][0]) : '0;
      rt = p2_pix.has_right ? SUM_W'(win[1][2]) : '0;
      ul = (p2_pix.has_up   && p2_pix.has_left)  ? SUM_W'(win[0][0]) : '0;
      ur = (p2_pix.has_up   && p2_pix.has_right) ? SUM_W'(win[0][2]) : '0;
      dl = (p2_pix.has_down && p2_pix.has_left)  ? SUM_W'(win[2][0]) : '0;
      dr = (p2_pix.has_down && p2_pix.has_right) ? SUM_W'(win[2][2]) : '0;

      own.sum   = SUM_W'(win[1][1]);
      own.cnt   = CNT_W'(1);
      ortho.sum = up + dn + lf + rt;
      ortho.cnt = CNT_W'(p2_pix.has_up) + CNT_W'(p2_pix.has_down) +
                  CNT_W'(p2_pix.has_left) + CNT_W'(p2_pix.has_right);
      diag.sum  = ul + ur + dl + dr;
      diag.cnt  = CNT_W'(p2_pix.has_up && p2_pix.has_left) +
                  CNT_W'(p2_pix.has_up && p2_pix.has_right) +
                  CNT_W'(p2_pix.has_down && p2_pix.has_left) +
                  CNT_W'(p2_pix.has_down && p2_pix.has_right);
      horiz.sum = lf + rt;
      horiz.cnt = CNT_W'(p2_pix.has_left) + CNT_W'(p2_pix.has_right);
      vert.sum  = up + dn;
      vert.cnt  = CNT_W'(p2_pix.has_up) + CNT_W'(p2_pix.has_down);
   end

   // Color role by Bayer phase: red at even/even, blue at odd/odd.
   always_comb begin
      case ({p2_pix.even_row, p2_pix.even_col})
         2'b11: begin
            red   = own;
            green = ortho;
            blue  = diag;
         end
         2'b00: begin
            blue  = own;
            green = ortho;
            red   = diag;
         end
         2'b10: begin
            green = own;
            red   = horiz;
            blue  = vert;
         end
         default: begin
            green = own;
            blue  = horiz;
            red   = vert;
         end
      endcase
   end

   // Handshake of the sum stage and the output register.
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      p3_free      = !p3_valid_ff || out_free;
      p3_valid_in  = p2_load || (p3_valid_ff && !out_free);
      rsp_valid_in = out_free ? p3_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff  <= p3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sum stage and output register payloads.
   always_ff @(posedge clock) begin
      if (p2_load) begin
         p3_blue_ff  <= blue;
         p3_green_ff <= green;
         p3_red_ff   <= red;
         p3_fe_ff    <= p2_pix.frame_end;
      end
      if (out_free && p3_valid_ff) begin
         rsp_blue_ff  <= mean(p3_blue_ff);
         rsp_green_ff <= mean(p3_green_ff);
         rsp_red_ff   <= mean(p3_red_ff);
         rsp_fe_ff    <= p3_fe_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue      = rsp_blue_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_frame_end = rsp_fe_ff;

endmodule

### rtl/bayer_bilinear_demosaic.sv
// Throughput: one request per cycle while rsp_stall is low; the line memory
//   takes a read and a write per cycle; the window shifts once per request.
// Path: registers p1, p2, p3 and rsp_ follow the take of the request that
//   completes a pixel's neighborhood, i.e. the sample W+1 positions after it.
// Reset: synchronous; clears counters, drain state and pipeline, and sets a
//   1024 x 1024 frame. The line memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming bilinear demosaic of an RGGB Bayer mosaic to BGR pixels.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [bbd_pkg::PIX_W-1:0]         req_sample,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bbd_pkg::PIX_W-1:0]         rsp_blue,
   output logic [bbd_pkg::PIX_W-1:0]         rsp_green,
   output logic [bbd_pkg::PIX_W-1:0]         rsp_red,
   output logic                              rsp_frame_end,
   // Register write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bbd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic              accept;
   logic              kept;
   logic              take;
   logic              p1_free;
   logic              p3_free;
   logic              p2_load;
   bbd_pkg::item_type item;
   bbd_pkg::pix_type  p2_pix;
   bbd_pkg::win_type  win;

   // Request acceptance; ignored requests are dropped at the door.
   assign csr_ready = 1'b1;
   assign req_stall = !p1_free;
   assign accept    = req_valid && !req_stall;
   assign take      = accept && kept;

   bbd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .accept        (accept),
      .req_operation (req_operation),
      .kept          (kept),
      .item          (item)
   );

   bbd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .item    (item),
      .sample  (req_sample),
      .p3_free (p3_free),
      .p1_free (p1_free),
      .p2_load (p2_load),
      .p2_pix  (p2_pix),
      .win     (win)
   );

   bbd_interp u_interp (
      .clock         (clock),
      .reset         (reset),
      .p2_load       (p2_load),
      .p2_pix        (p2_pix),
      .win           (win),
      .rsp_stall     (rsp_stall),
      .p3_free       (p3_free),
      .rsp_valid     (rsp_valid),
      .rsp_blue      (rsp_blue),
      .rsp_green     (rsp_green),
      .rsp_red       (rsp_red),
      .rsp_frame_end (rsp_frame_end)
   );

   // The last pixel of a frame is always emitted by a drain request.
   a_frame_end_from_drain: assert property (@(posedge clock) disable iff (reset)
      (take && item.pix.emit && item.pix.frame_end) |-> !item.is_sample)
      else $error("frame end pixel emitted by a sample request");

   // A drain request that is not dropped always produces a pixel.
   a_drain_emits: assert property (@(posedge clock) disable iff (reset)
      (take && !item.is_sample) |-> item.pix.emit)
      else $error("drain request taken without a pixel");

   // Reset empties the output register.
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

### sim/bayer_bilinear_demosaic_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_test
// Self-checking testbench for the RGGB bilinear demosaic block. It runs a
// short directed table (small frames, extreme samples, ignored requests,
// stream restart, unused register index). Two frames at the size limits
// follow, each cut short, then random frames of random geometry. Each pixel
// is checked against a predictor or table entry; both stream sides idle at random.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_test;

   localparam int          RANDOM_ITEMS  = 420;
   localparam int          CALM_ITEMS    = 120;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          TAIL_CYCLES   = 20;
   localparam int          LONG_HOLD     = 400;
   localparam int          CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned NEVER         = 32'hFFFF_FFFF;

   // Register indexes past the implemented ones.
   localparam logic [bbd_pkg::CSR_INDEX_W-1:0] SPARE_INDEX = 2'd2;
   localparam logic [bbd_pkg::CSR_INDEX_W-1:0] LAST_INDEX  = 2'd3;

   typedef struct packed {
      logic [bbd_pkg::PIX_W-1:0] blue;
      logic [bbd_pkg::PIX_W-1:0] green;
      logic [bbd_pkg::PIX_W-1:0] red;
      logic                      frame_end;
   } pixel_type;

   typedef enum logic {
      STEP_REQUEST,
      STEP_REGISTER
   } step_kind_type;

   typedef struct packed {
      step_kind_type                     kind;
      logic [bbd_pkg::CSR_INDEX_W-1:0]   index;
      logic [bbd_pkg::CSR_DATA_W-1:0]    data;
      bbd_pkg::op_type                   op;
      logic [bbd_pkg::PIX_W-1:0]         smp;
      logic                              typed;
      pixel_type                         want;
   } step_type;

   typedef enum {
      AROUND_SELF,
      AROUND_CROSS,
      AROUND_DIAG,
      AROUND_ROW,
      AROUND_COL
   } shape_type;

   localparam pixel_type NO_PIXEL    = '0;
   localparam pixel_type WHITE       = '{8'hFF, 8'hFF, 8'hFF, 1'b0};
   localparam pixel_type WHITE_LAST  = '{8'hFF, 8'hFF, 8'hFF, 1'b1};
   localparam pixel_type BLACK       = '{8'h00, 8'h00, 8'h00, 1'b0};
   localparam pixel_type BLACK_LAST  = '{8'h00, 8'h00, 8'h00, 1'b1};

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic                            req_stall;
   logic                            req_operation = 1'b0;
   logic [bbd_pkg::PIX_W-1:0]       req_sample    = '0;
   logic                            rsp_valid;
   logic                            rsp_stall     = 1'b0;
   logic [bbd_pkg::PIX_W-1:0]       rsp_blue;
   logic [bbd_pkg::PIX_W-1:0]       rsp_green;
   logic [bbd_pkg::PIX_W-1:0]       rsp_red;
   logic                            rsp_frame_end;
   logic                            csr_valid     = 1'b0;
   logic                            csr_ready;
   logic [bbd_pkg::CSR_INDEX_W-1:0] csr_index     = '0;
   logic [bbd_pkg::CSR_DATA_W-1:0]  csr_wdata     = '0;

   // Run bookkeeping.
   pixel_type   expected_pixels [$];
   int          mismatches      = 0;
   int          cycle_count     = 0;
   int          useful_items    = 0;
   int          frames_seen     = 0;
   int          gap_pct         = 0;
   int          stall_pct       = 0;
   bit          long_hold_pending = 1'b0;
   step_type    plan [29];

   // Predictor state.
   logic [bbd_pkg::CFG_WIDTH_W-1:0]  columns_reg;
   logic [bbd_pkg::CFG_HEIGHT_W-1:0] rows_reg;
   logic [bbd_pkg::PIX_W-1:0]        line_copy [2*bbd_pkg::MAX_WIDTH+2];
   int                               in_col, in_row, out_col, out_row;
   bit                               flushing;
   int                               cur_cols, cur_rows;
   bit                               latest_ok;
   int                               latest_pos;
   logic [bbd_pkg::PIX_W-1:0]        latest_value;

   bayer_bilinear_demosaic u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_blue      (rsp_blue),
      .rsp_green     (rsp_green),
      .rsp_red       (rsp_red),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Frame geometry as the block uses it, after clamping.
   function automatic int frame_columns();
      if (columns_reg < 2) return 2;
      if (columns_reg > bbd_pkg::MAX_WIDTH) return bbd_pkg::MAX_WIDTH;
      return int'(columns_reg);
   endfunction

   function automatic int frame_rows();
      if (rows_reg < 2) return 2;
      if (rows_reg > bbd_pkg::MAX_HEIGHT) return bbd_pkg::MAX_HEIGHT;
      return int'(rows_reg);
   endfunction

   function automatic void restart_stream();
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
      flushing = 1'b0;
   endfunction

   function automatic void apply_register(input logic [bbd_pkg::CSR_INDEX_W-1:0] index,
                                          input logic [bbd_pkg::CSR_DATA_W-1:0] data);
      if (index == bbd_pkg::CSR_FRAME_WIDTH) begin
         columns_reg = data[bbd_pkg::CFG_WIDTH_W-1:0];
         restart_stream();
      end else if (index == bbd_pkg::CSR_FRAME_HEIGHT) begin
         rows_reg = data[bbd_pkg::CFG_HEIGHT_W-1:0];
         restart_stream();
      end
   endfunction

   // Truncated mean of the in-frame neighbors of (r, c) in the given shape.
   // The sample that arrives with this request is not yet in the line copy.
   function automatic logic [bbd_pkg::PIX_W-1:0] neighbor_mean(input int r, input int c,
                                                               input shape_type shape);
      int dr [4];
      int dc [4];
      int n, rr, cc, pos, sum, cnt;
      dr  = '{0, 0, 0, 0};
      dc  = '{0, 0, 0, 0};
      n   = 2;
      sum = 0;
      cnt = 0;
      case (shape)
         AROUND_SELF: n = 1;
         AROUND_CROSS: begin
            n  = 4;
            dr = '{-1, 1, 0, 0};
            dc = '{0, 0, -1, 1};
         end
         AROUND_DIAG: begin
            n  = 4;
            dr = '{-1, -1, 1, 1};
            dc = '{-1, 1, -1, 1};
         end
         AROUND_ROW: dc = '{-1, 1, 0, 0};
         default: dr = '{-1, 1, 0, 0};
      endcase
      for (int i = 0; i < n; i++) begin
         rr = r + dr[i];
         cc = c + dc[i];
         if (rr >= 0 && cc >= 0 && rr < cur_rows && cc < cur_cols) begin
            pos = rr * cur_cols + cc;
            if (latest_ok && pos == latest_pos) begin
               sum += int'(latest_value);
            end else begin
               sum += int'(line_copy[pos % (2 * cur_cols + 2)]);
            end
            cnt++;
         end
      end
      return (cnt == 0) ? '0 : bbd_pkg::PIX_W'(sum / cnt);
   endfunction

   // Pixel at the output position; moves the output position on.
   function automatic pixel_type next_pixel();
      pixel_type px;
      bit        even_r, even_c;
      even_r       = (out_row % 2) == 0;
      even_c       = (out_col % 2) == 0;
      px.frame_end = 1'b0;
      if (even_r && even_c) begin
         px.red   = neighbor_mean(out_row, out_col, AROUND_SELF);
         px.green = neighbor_mean(out_row, out_col, AROUND_CROSS);
         px.blue  = neighbor_mean(out_row, out_col, AROUND_DIAG);
      end else if (!even_r && !even_c) begin
         px.blue  = neighbor_mean(out_row, out_col, AROUND_SELF);
         px.green = neighbor_mean(out_row, out_col, AROUND_CROSS);
         px.red   = neighbor_mean(out_row, out_col, AROUND_DIAG);
      end else if (even_r) begin
         px.green = neighbor_mean(out_row, out_col, AROUND_SELF);
         px.red   = neighbor_mean(out_row, out_col, AROUND_ROW);
         px.blue  = neighbor_mean(out_row, out_col, AROUND_COL);
      end else begin
         px.green = neighbor_mean(out_row, out_col, AROUND_SELF);
         px.blue  = neighbor_mean(out_row, out_col, AROUND_ROW);
         px.red   = neighbor_mean(out_row, out_col, AROUND_COL);
      end
      out_col++;
      if (out_col >= cur_cols) begin
         out_col = 0;
         out_row++;
         if (out_row >= cur_rows) begin
            out_row      = 0;
            px.frame_end = 1'b1;
            flushing     = 1'b0;
            frames_seen++;
         end
      end
      return px;
   endfunction

   // One request through the demosaic; returns 1 when it yields a pixel.
   function automatic bit demosaic_step(input bbd_pkg::op_type op,
                                        input logic [bbd_pkg::PIX_W-1:0] smp,
                                        output pixel_type px, output bit took);
      int pos;
      bit made;
      cur_cols = frame_columns();
      cur_rows = frame_rows();
      px       = NO_PIXEL;
      made     = 1'b0;
      took     = (op == bbd_pkg::OP_DRAIN) == flushing;
      if (!took) return 1'b0;
      if (op == bbd_pkg::OP_DRAIN) begin
         latest_ok = 1'b0;
         px        = next_pixel();
         return 1'b1;
      end
      pos          = in_row * cur_cols + in_col;
      latest_ok    = 1'b1;
      latest_pos   = pos;
      latest_value = smp;
      if (pos >= cur_cols + 1) begin
         px   = next_pixel();
         made = 1'b1;
      end
      line_copy[pos % (2 * cur_cols + 2)] = smp;
      in_col++;
      if (in_col >= cur_cols) begin
         in_col = 0;
         in_row++;
         if (in_row >= cur_rows) begin
            in_row   = 0;
            flushing = 1'b1;
         end
      end
      return made;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 40) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      end
      mismatches++;
   endtask

   // Offer one request, wait for it to be taken, and record what it should yield.
   task automatic send_request(input bbd_pkg::op_type op,
                               input logic [bbd_pkg::PIX_W-1:0] smp,
                               input logic typed, input pixel_type want);
      pixel_type px;
      bit        took, made;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_sample    <= smp;
      do @(posedge clock); while (req_stall);
      made = demosaic_step(op, smp, px, took);
      if (took) useful_items++;
      if (made) expected_pixels.push_back(typed ? want : px);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Register writes happen only once the block has gone quiet.
   task automatic write_register(input logic [bbd_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [bbd_pkg::CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_register(index, data);
   endtask

   // Stream requests that mostly follow the frame protocol, with stray drains
   // and samples mixed in, until enough frames end or the item budget runs out.
   task automatic run_phase(input int frame_goal, input int unsigned item_cap,
                            input int unsigned hold_at, input int unsigned pause_at);
      int unsigned               sent;
      int                        first_frame;
      bit                        stray;
      bbd_pkg::op_type           op;
      logic [bbd_pkg::PIX_W-1:0] smp;
      sent        = 0;
      first_frame = frames_seen;
      while (frames_seen - first_frame < frame_goal && sent < item_cap) begin
         if (sent == hold_at) long_hold_pending = 1'b1;
         if (sent == pause_at || (gap_pct != 0 && $urandom_range(0, 199) == 0)) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_pixels.size() != 0);
         end
         stray = ($urandom_range(0, 15) == 0);
         if (flushing != stray) begin
            op = bbd_pkg::OP_DRAIN;
         end else begin
            op = bbd_pkg::OP_SAMPLE;
         end
         if ($urandom_range(0, 3) == 0) begin
            smp = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         end else begin
            smp = bbd_pkg::PIX_W'($urandom_range(0, 255));
         end
         send_request(op, smp, 1'b0, NO_PIXEL);
         sent++;
      end
   endtask

   // Result side: random stall bursts, plus one long hold on request.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stall_left        = LONG_HOLD;
         end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 19);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Compare every accepted pixel with the oldest expectation.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("pixel arrived with none expected");
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_blue !== want.blue)
               report_mismatch($sformatf("blue %0d, expected %0d", rsp_blue, want.blue));
            if (rsp_green !== want.green)
               report_mismatch($sformatf("green %0d, expected %0d", rsp_green, want.green));
            if (rsp_red !== want.red)
               report_mismatch($sformatf("red %0d, expected %0d", rsp_red, want.red));
            if (rsp_frame_end !== want.frame_end)
               report_mismatch($sformatf("frame_end %0d, expected %0d",
                                         rsp_frame_end, want.frame_end));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int random_base, area, frame_goal;
      int unsigned item_cap, budget_left;
      logic [bbd_pkg::CFG_WIDTH_W-1:0]  width_value;
      logic [bbd_pkg::CFG_HEIGHT_W-1:0] height_value;

      // Directed frames of 2 x 2; typed rows are uniform frames.
      plan = '{
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'hA5, 1'b0, NO_PIXEL},
         '{STEP_REGISTER, bbd_pkg::CSR_FRAME_WIDTH,  13'h1800, bbd_pkg::OP_SAMPLE, 8'h00,
           1'b0, NO_PIXEL},
         '{STEP_REGISTER, bbd_pkg::CSR_FRAME_HEIGHT, 13'd1,    bbd_pkg::OP_SAMPLE, 8'h00,
           1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'hFF, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'hFF, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'hFF, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'hFF, 1'b1, WHITE},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h5A, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b1, WHITE},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b1, WHITE},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b1, WHITE_LAST},
         '{STEP_REGISTER, LAST_INDEX, 13'h1FFF, bbd_pkg::OP_SAMPLE, 8'h00, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h00, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h00, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h00, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h00, 1'b1, BLACK},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b1, BLACK},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b1, BLACK},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b1, BLACK_LAST},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h77, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h12, 1'b0, NO_PIXEL},
         '{STEP_REGISTER, bbd_pkg::CSR_FRAME_WIDTH, 13'd2, bbd_pkg::OP_SAMPLE, 8'h00,
           1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h00, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'hFF, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'hFE, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_SAMPLE, 8'h01, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b0, NO_PIXEL},
         '{STEP_REQUEST,  '0, '0, bbd_pkg::OP_DRAIN,  8'h00, 1'b0, NO_PIXEL}
      };

      // Predictor starts from the reset state of the block.
      columns_reg = bbd_pkg::CFG_WIDTH_W'(1024);
      rows_reg    = bbd_pkg::CFG_HEIGHT_W'(1024);
      restart_stream();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      gap_pct   = 15;
      stall_pct = 15;
      foreach (plan[i]) begin
         if (plan[i].kind == STEP_REGISTER) begin
            write_register(plan[i].index, plan[i].data);
         end else begin
            send_request(plan[i].op, plan[i].smp, plan[i].typed, plan[i].want);
         end
      end

      // Widest frame, cut short; hold the result side while pixels flow,
      // then pause until every pixel is out.
      write_register(bbd_pkg::CSR_FRAME_WIDTH, bbd_pkg::CSR_DATA_W'(bbd_pkg::MAX_WIDTH));
      write_register(bbd_pkg::CSR_FRAME_HEIGHT, bbd_pkg::CSR_DATA_W'(2));
      gap_pct   = 10;
      stall_pct = 10;
      run_phase(1, 1300, 1150, 1250);

      // Tallest frame: the height register is clamped to its limit; only the
      // first rows are sent.
      write_register(bbd_pkg::CSR_FRAME_WIDTH, bbd_pkg::CSR_DATA_W'(2));
      write_register(bbd_pkg::CSR_FRAME_HEIGHT, 13'h1FFF);
      gap_pct   = 5;
      stall_pct = 5;
      run_phase(1, 100, NEVER, NEVER);

      // Random geometry, mostly small frames, some clamped or cut short.
      random_base = useful_items;
      while (useful_items - random_base < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       width_value = bbd_pkg::CFG_WIDTH_W'($urandom_range(0, 2047));
            1:       width_value = bbd_pkg::CFG_WIDTH_W'($urandom_range(0, 1));
            default: width_value = bbd_pkg::CFG_WIDTH_W'($urandom_range(2, 9));
         endcase
         case ($urandom_range(0, 9))
            0:       height_value = bbd_pkg::CFG_HEIGHT_W'($urandom_range(0, 8191));
            1:       height_value = bbd_pkg::CFG_HEIGHT_W'($urandom_range(0, 1));
            default: height_value = bbd_pkg::CFG_HEIGHT_W'($urandom_range(2, 7));
         endcase
         write_register(bbd_pkg::CSR_FRAME_WIDTH, {2'($urandom_range(0, 3)), width_value});
         write_register(bbd_pkg::CSR_FRAME_HEIGHT, height_value);
         if ($urandom_range(0, 9) == 0) begin
            write_register(($urandom_range(0, 1) != 0) ? SPARE_INDEX : LAST_INDEX,
                           bbd_pkg::CSR_DATA_W'($urandom_range(0, 8191)));
         end

         // Idling settings per phase; none at all near the end.
         if (useful_items - random_base > RANDOM_ITEMS - CALM_ITEMS) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: gap_pct = 0;
               1: gap_pct = 3;
               2: gap_pct = 15;
               default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 3;
               2: stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end

         area = frame_columns() * frame_rows();
         if (area > 400 || $urandom_range(0, 5) == 0) begin
            frame_goal = 3;
            item_cap   = $urandom_range(1, 300);
         end else begin
            frame_goal = $urandom_range(1, 3);
            item_cap   = NEVER;
         end
         // Keep the random part close to its item budget.
         budget_left = unsigned'(RANDOM_ITEMS - (useful_items - random_base) + 20);
         if (item_cap > budget_left) item_cap = budget_left;
         run_phase(frame_goal, item_cap, NEVER, NEVER);
      end

      // Let every pixel come out, then allow the pipeline to settle.
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
rtl/bbd_pkg.sv
rtl/bbd_ram.sv
rtl/bbd_ctrl.sv
rtl/bbd_window.sv
rtl/bbd_interp.sv
rtl/bayer_bilinear_demosaic.sv
sim/bayer_bilinear_demosaic_test.sv
